// ===== hw/rtl/fully_associative_fifo_tag_store_unit_defines.svh =====
// assertion macros for the fully associative tag store
// used by the top level; expects signals named clk and rst in scope
`ifndef FULLY_ASSOCIATIVE_FIFO_TAG_STORE_UNIT_DEFINES_SVH
`define FULLY_ASSOCIATIVE_FIFO_TAG_STORE_UNIT_DEFINES_SVH

// same-cycle implication
`define FATSU_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tag store check failed");

// next-cycle implication
`define FATSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tag store check failed");

`endif

// ===== hw/rtl/fatsu_pkg.sv =====
// shared types and constants for the fully associative tag store
// no dependencies
package fatsu_pkg;

  localparam int MAX_LINES  = 1024;
  localparam int IDX_W      = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int CNT_W      = $clog2(MAX_LINES + 1);
  localparam int ADDR_W     = 31;
  localparam int TAG_W      = 31;
  localparam int LC_W       = 11;
  localparam int BS_W       = 17;
  localparam int TOTAL_W    = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 128;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 17;

  localparam int DIV_STEPS  = ADDR_W;
  localparam int DSTEP_W    = $clog2(DIV_STEPS);

  localparam int GROUP_SIZE = 32;
  localparam int GROUPS     = (MAX_LINES + GROUP_SIZE - 1) / GROUP_SIZE;

  localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;
  localparam logic [LC_W-1:0] LINE_COUNT_RESET = LC_W'(1024);
  localparam logic [BS_W-1:0] BLOCK_SIZE_RESET = BS_W'(16);

  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MATCH,
    S_GROUP,
    S_REDUCE,
    S_COMMIT
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_APPEND,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t         op;
    logic [TAG_W-1:0] key;
    logic [CNT_W-1:0] used;
    logic [IDX_W-1:0] write_pos;
    logic [IDX_W-1:0] last_pos;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/fatsu_cell.sv =====
// one tag line of the chain: compares against the broadcast key and
// takes its neighbour's tag on a shift; depends on fatsu_pkg
module fatsu_cell (
  input  logic                        clk,
  input  logic [fatsu_pkg::IDX_W-1:0] index,
  input  fatsu_pkg::cell_ctrl_t       ctrl,
  input  logic [fatsu_pkg::TAG_W-1:0] next_tag,
  output logic [fatsu_pkg::TAG_W-1:0] tag,
  output logic                        match
);
  import fatsu_pkg::*;

  logic [TAG_W-1:0] tag_next;
  logic             in_use;

  always_comb begin
    in_use   = CNT_W'(index) < ctrl.used;
    tag_next = tag;
    case (ctrl.op)
      CELL_APPEND: begin
        if (index == ctrl.write_pos) begin
          tag_next = ctrl.key;
        end
      end
      CELL_SHIFT: begin
        if (index < ctrl.last_pos) begin
          tag_next = next_tag;
        end else if (index == ctrl.last_pos) begin
          tag_next = ctrl.key;
        end
      end
      default: begin
        tag_next = tag;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    tag   <= tag_next;
    match <= in_use && (tag == ctrl.key);
  end

endmodule

// ===== hw/rtl/fatsu_div.sv =====
// bit-serial restoring divider, one quotient bit per cycle
// depends on fatsu_pkg
module fatsu_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fatsu_pkg::ADDR_W-1:0] dividend,
  input  logic [fatsu_pkg::BS_W-1:0]   divisor,
  output logic                         done,
  output logic [fatsu_pkg::ADDR_W-1:0] quotient
);
  import fatsu_pkg::*;

  logic               busy;
  logic [DSTEP_W-1:0] count;
  logic [ADDR_W-1:0]  quo;
  logic [BS_W-1:0]    rem;
  logic [BS_W-1:0]    dvs;
  logic [BS_W:0]      shifted;
  logic [BS_W:0]      diff;
  logic               ge;

  always_comb begin
    shifted = {rem, quo[ADDR_W-1]};
    ge      = shifted >= {1'b0, dvs};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
        quo   <= dividend;
        rem   <= '0;
        dvs   <= divisor;
      end else if (busy) begin
        quo   <= {quo[ADDR_W-2:0], ge};
        rem   <= ge ? diff[BS_W-1:0] : shifted[BS_W-1:0];
        count <= count + DSTEP_W'(1);
        if (count == DSTEP_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== hw/rtl/fully_associative_fifo_tag_store_unit.sv =====
// fully associative tag store with fifo replacement, chain of tag cells
// one item at a time: each accepted address passes through the 31-step serial
// divider, then match, two-level or tree and commit before the next is taken
// the result register frees the input side while a result waits
// synchronous reset clears fill count, totals and handshakes, restores config defaults; tags hold
// depends on fatsu_pkg, fatsu_div, fatsu_cell and the assertion macro header
`include "fully_associative_fifo_tag_store_unit_defines.svh"

module fully_associative_fifo_tag_store_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // address[30:0], zero pad
  input  logic [fatsu_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // hit, evicted, evicted_tag[30:0], access_tag[30:0], hit_total[31:0],
  // miss_total[31:0]
  output logic [fatsu_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fatsu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fatsu_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fatsu_pkg::*;

  state_t             state;
  state_t             state_next;
  logic [LC_W-1:0]    line_count;
  logic [BS_W-1:0]    block_size;
  logic [CNT_W-1:0]   fill_count;
  logic [CNT_W-1:0]   fill_count_next;
  logic [TOTAL_W-1:0] hit_count;
  logic [TOTAL_W-1:0] hit_count_next;
  logic [TOTAL_W-1:0] miss_count;
  logic [TOTAL_W-1:0] miss_count_next;
  logic [TAG_W-1:0]   key;
  logic               hit;
  logic [GROUPS-1:0]  group_hit;

  logic               div_start;
  logic               div_done;
  logic [ADDR_W-1:0]  quotient;
  logic [BS_W-1:0]    bs_eff;
  logic [CNT_W-1:0]   n_eff;
  logic               full;
  logic               commit;
  logic               evicted;
  logic [TAG_W-1:0]   evicted_tag;
  cell_ctrl_t         ctrl;

  logic [TAG_W-1:0]             tags [MAX_LINES];
  logic [MAX_LINES-1:0]         match;
  logic [GROUPS*GROUP_SIZE-1:0] match_pad;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= LINE_COUNT_RESET;
      block_size <= BLOCK_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LINE_COUNT: line_count <= cfg_data[LC_W-1:0];
        REG_BLOCK_SIZE: block_size <= cfg_data[BS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    bs_eff = (block_size == '0) ? BS_W'(1) : block_size;
    if (line_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(line_count) > 32'(MAX_LINES)) begin
      n_eff = CNT_W'(MAX_LINES);
    end else begin
      n_eff = CNT_W'(line_count);
    end
    full = fill_count >= n_eff;
  end

  fatsu_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (s_tdata[ADDR_W-1:0]),
    .divisor  (bs_eff),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    div_start  = 1'b0;
    commit     = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          div_start  = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_next = S_MATCH;
        end
      end
      S_MATCH:  state_next = S_GROUP;
      S_GROUP:  state_next = S_REDUCE;
      S_REDUCE: state_next = S_COMMIT;
      S_COMMIT: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      key <= quotient[TAG_W-1:0];
    end
  end

  always_comb begin
    ctrl.key       = key;
    ctrl.used      = (fill_count < n_eff) ? fill_count : n_eff;
    ctrl.write_pos = fill_count[IDX_W-1:0];
    ctrl.last_pos  = IDX_W'(n_eff - CNT_W'(1));
    ctrl.op        = CELL_HOLD;
    if (commit && !hit) begin
      ctrl.op = full ? CELL_SHIFT : CELL_APPEND;
    end
  end

  genvar i;
  generate
    for (i = 0; i < MAX_LINES; i++) begin : g_cell
      if (i == MAX_LINES - 1) begin : g_end
        fatsu_cell u_cell (
          .clk      (clk),
          .index    (IDX_W'(i)),
          .ctrl     (ctrl),
          .next_tag ('0),
          .tag      (tags[i]),
          .match    (match[i])
        );
      end else begin : g_mid
        fatsu_cell u_cell (
          .clk      (clk),
          .index    (IDX_W'(i)),
          .ctrl     (ctrl),
          .next_tag (tags[i+1]),
          .tag      (tags[i]),
          .match    (match[i])
        );
      end
    end
  endgenerate

  assign match_pad = (GROUPS*GROUP_SIZE)'(match);

  generate
    for (i = 0; i < GROUPS; i++) begin : g_group
      always_ff @(posedge clk) begin
        group_hit[i] <= |match_pad[i*GROUP_SIZE +: GROUP_SIZE];
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (state == S_REDUCE) begin
      hit <= |group_hit;
    end
  end

  always_comb begin
    evicted         = !hit && full;
    evicted_tag     = evicted ? tags[0] : '0;
    fill_count_next = fill_count;
    hit_count_next  = hit_count;
    miss_count_next = miss_count;
    if (hit) begin
      if (hit_count != COUNT_MAX) begin
        hit_count_next = hit_count + TOTAL_W'(1);
      end
    end else begin
      fill_count_next = full ? n_eff : fill_count + CNT_W'(1);
      if (miss_count != COUNT_MAX) begin
        miss_count_next = miss_count + TOTAL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      hit_count  <= '0;
      miss_count <= '0;
    end else if (commit) begin
      fill_count <= fill_count_next;
      hit_count  <= hit_count_next;
      miss_count <= miss_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {miss_count_next, hit_count_next, key, evicted_tag, evicted, hit};
    end
  end

  `FATSU_ASSERT_NOW(a_done_in_div, div_done, state == S_DIV)
  `FATSU_ASSERT_NEXT(a_full_miss_fill, commit && !hit && full, fill_count == $past(n_eff))
  `FATSU_ASSERT_NEXT(a_hit_keeps_fill, commit && hit, $stable(fill_count))
  `FATSU_ASSERT_NEXT(a_miss_counts,
    commit && !hit, miss_count == $past(miss_count) + 32'd1 || miss_count == COUNT_MAX)

endmodule
